[rtl/plba_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plba_pkg
// Shared types and constants for the price level book aggregator.
// ----------------------------------------------------------------------------
package plba_pkg;

    localparam int DATA_W          = 32;
    localparam int MASK_W          = 8;
    localparam int EXCH_W          = 3;
    localparam int EXCH_COUNT      = 8;
    localparam int TABLE_DEPTH_DEF = 64;

    localparam logic [MASK_W-1:0] MASK_RESET = '1;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_EMIT = 1'b1;

    // one table row: price plus both side sums
    typedef struct packed {
        logic [DATA_W-1:0] price;
        logic [DATA_W-1:0] bid;
        logic [DATA_W-1:0] ask;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic lt;
        logic eq;
    } alu_flags_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LO,
        ST_HI,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_UPD,
        ST_SHF_RD,
        ST_SHF_WR,
        ST_INS,
        ST_EM_START,
        ST_EM_RD,
        ST_EM_OUT
    } state_t;

endpackage

[rtl/plba_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plba_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module plba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/plba_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plba_alu
// Shared 32-bit add / subtract unit with unsigned compare flags.
// ----------------------------------------------------------------------------
module plba_alu
    import plba_pkg::*;
(
    input  logic [DATA_W-1:0] a,
    input  logic [DATA_W-1:0] b,
    input  logic              sub,
    output logic [DATA_W-1:0] result,
    output alu_flags_t        flags
);

    logic [DATA_W:0]   sum;
    logic [DATA_W-1:0] b_op;

    assign b_op = sub ? ~b : b;
    assign sum  = {1'b0, a} + {1'b0, b_op} + {{DATA_W{1'b0}}, sub};

    assign result   = sum[DATA_W-1:0];
    // borrow out of a - b means a < b
    assign flags.lt = sub & ~sum[DATA_W];
    assign flags.eq = (a == b);

endmodule

[rtl/price_level_book_aggregator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// price_level_book_aggregator_top
// Sorted price-level table with per-side sums, streamed out on emit.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall, one request per level (op 0) or emit
// (op 1). in_stall is high whenever the sequencer is busy; one request is
// worked on at a time.
// Output channel: out_valid / out_stall from an output register. An emit
// gives one result per table entry in ascending price order (or a single
// empty result) and the final one carries last.
// Config channel: cfg_valid / cfg_ready, writes the exchange enable mask;
// cfg_ready is always high.
// Sequencing: the table sits in one RAM with one read and one write port and
// a registered read. An add holds in_stall through the min/max update, the
// search up to the insert point, the shift of the rows above it and the write
// of the new row; a masked or zero-price level keeps the block idle. An emit
// holds in_stall while it reads the entries in turn and while the receiver
// holds out_stall; the sequencer waits on a full output register. The first
// result passes the start, read and output states and the output register,
// and a new request is taken no sooner than the cycle after the sequencer
// finishes.
// Reset empties the table and sets the mask to all ones; no clearing pass.
// ----------------------------------------------------------------------------
module price_level_book_aggregator_top
    import plba_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              op,
    input  logic [EXCH_W-1:0] exchange_id,
    input  logic              is_ask,
    input  logic [DATA_W-1:0] price,
    input  logic [DATA_W-1:0] size,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DATA_W-1:0] level_price,
    output logic [DATA_W-1:0] bid_total,
    output logic [DATA_W-1:0] ask_total,
    output logic [DATA_W-1:0] combined_count,
    output logic [DATA_W-1:0] low_price,
    output logic [DATA_W-1:0] price_spread,
    output logic              level_valid,
    output logic              last,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [MASK_W-1:0] cfg_data
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    state_t state_reg, state_next;

    logic [MASK_W-1:0] mask_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  pos_reg;
    logic [ADDR_W-1:0] dst_reg;
    logic [ADDR_W-1:0] k_reg;
    logic [DATA_W-1:0] lowest_reg;
    logic [DATA_W-1:0] highest_reg;
    logic              any_reg;
    logic              out_valid_reg;

    logic              op_reg;
    logic              is_ask_reg;
    logic [DATA_W-1:0] price_reg;
    logic [DATA_W-1:0] size_reg;
    logic [DATA_W-1:0] base_reg;
    logic [DATA_W-1:0] range_reg;

    logic [DATA_W-1:0] level_price_reg;
    logic [DATA_W-1:0] bid_total_reg;
    logic [DATA_W-1:0] ask_total_reg;
    logic [DATA_W-1:0] combined_count_reg;
    logic [DATA_W-1:0] low_price_reg;
    logic [DATA_W-1:0] price_spread_reg;
    logic              level_valid_reg;
    logic              last_reg;

    // table RAM
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    entry_t            ram_wr_data;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    entry_t            ram_rd_data;

    // shared arithmetic unit
    logic [DATA_W-1:0] alu_a;
    logic [DATA_W-1:0] alu_b;
    logic              alu_sub;
    logic [DATA_W-1:0] alu_res;
    alu_flags_t        alu_flags;

    logic              in_take;
    logic              exch_on;
    logic              slot_free;
    logic              out_load;
    logic              count_full;
    logic              pos_at_end;
    logic              shift_more;
    logic              emit_last;
    logic [ADDR_W-1:0] dst_init;

    plba_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    plba_alu u_alu (
        .a      (alu_a),
        .b      (alu_b),
        .sub    (alu_sub),
        .result (alu_res),
        .flags  (alu_flags)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid & ~in_stall;
    assign cfg_ready = 1'b1;
    assign exch_on   = (32'(exchange_id) < EXCH_COUNT) && mask_reg[exchange_id];

    assign slot_free  = ~out_valid_reg | ~out_stall;
    assign count_full = (count_reg == CNT_W'(TABLE_DEPTH));
    assign pos_at_end = (pos_reg == count_reg);
    assign shift_more = (CNT_W'(dst_reg) > pos_reg);
    assign emit_last  = (count_reg == '0) ||
                        ((CNT_W'(k_reg) + CNT_W'(1)) == count_reg);
    // top row written by the shift: the next free row, or the last row when full
    assign dst_init   = count_full ? ADDR_W'(TABLE_DEPTH - 1) : count_reg[ADDR_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (op == OP_EMIT)
                    begin
                        state_next = ST_EM_START;
                    end
                    else if (exch_on && (price != '0))
                    begin
                        state_next = ST_LO;
                    end
                end
            end
            ST_LO:       state_next = ST_HI;
            ST_HI:       state_next = ST_SRCH_RD;
            ST_SRCH_RD:
            begin
                if (!pos_at_end)
                begin
                    state_next = ST_SRCH_CMP;
                end
                else if (count_full)
                begin
                    // above every entry of a full table: not stored
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SHF_RD;
                end
            end
            ST_SRCH_CMP:
            begin
                if (alu_flags.lt)
                begin
                    state_next = ST_SRCH_RD;
                end
                else if (alu_flags.eq)
                begin
                    state_next = ST_UPD;
                end
                else
                begin
                    state_next = ST_SHF_RD;
                end
            end
            ST_UPD:      state_next = ST_IDLE;
            ST_SHF_RD:   state_next = shift_more ? ST_SHF_WR : ST_INS;
            ST_SHF_WR:   state_next = ST_SHF_RD;
            ST_INS:      state_next = ST_IDLE;
            ST_EM_START: state_next = ST_EM_RD;
            ST_EM_RD:    state_next = ST_EM_OUT;
            ST_EM_OUT:
            begin
                if (slot_free)
                begin
                    state_next = emit_last ? ST_IDLE : ST_EM_RD;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath controls
    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = pos_reg[ADDR_W-1:0];
        ram_wr_data = ram_rd_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = pos_reg[ADDR_W-1:0];
        alu_a       = price_reg;
        alu_b       = lowest_reg;
        alu_sub     = 1'b1;
        out_load    = 1'b0;
        unique case (state_reg)
            ST_LO:
            begin
                alu_a = price_reg;
                alu_b = lowest_reg;
            end
            ST_HI:
            begin
                alu_a = highest_reg;
                alu_b = price_reg;
            end
            ST_SRCH_RD:
            begin
                ram_rd_en = ~pos_at_end;
            end
            ST_SRCH_CMP:
            begin
                alu_a = ram_rd_data.price;
                alu_b = price_reg;
            end
            ST_UPD:
            begin
                alu_a     = is_ask_reg ? ram_rd_data.ask : ram_rd_data.bid;
                alu_b     = size_reg;
                alu_sub   = 1'b0;
                ram_wr_en = 1'b1;
                if (is_ask_reg)
                begin
                    ram_wr_data.ask = alu_res;
                end
                else
                begin
                    ram_wr_data.bid = alu_res;
                end
            end
            ST_SHF_RD:
            begin
                ram_rd_en   = shift_more;
                ram_rd_addr = dst_reg - ADDR_W'(1);
            end
            ST_SHF_WR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = dst_reg;
            end
            ST_INS:
            begin
                ram_wr_en         = 1'b1;
                ram_wr_data.price = price_reg;
                ram_wr_data.bid   = is_ask_reg ? '0 : size_reg;
                ram_wr_data.ask   = is_ask_reg ? size_reg : '0;
            end
            ST_EM_START:
            begin
                alu_a = highest_reg;
                alu_b = lowest_reg;
            end
            ST_EM_RD:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = k_reg;
            end
            ST_EM_OUT:
            begin
                alu_a    = ram_rd_data.bid;
                alu_b    = ram_rd_data.ask;
                alu_sub  = 1'b0;
                out_load = slot_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mask_reg      <= MASK_RESET;
            count_reg     <= '0;
            pos_reg       <= '0;
            dst_reg       <= '0;
            k_reg         <= '0;
            lowest_reg    <= '1;
            highest_reg   <= '0;
            any_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                mask_reg <= cfg_data;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_LO:
                begin
                    if (!any_reg || alu_flags.lt)
                    begin
                        lowest_reg <= price_reg;
                    end
                end
                ST_HI:
                begin
                    if (!any_reg || alu_flags.lt)
                    begin
                        highest_reg <= price_reg;
                    end
                    any_reg <= 1'b1;
                    pos_reg <= '0;
                end
                ST_SRCH_RD:
                begin
                    if (pos_at_end)
                    begin
                        dst_reg <= dst_init;
                    end
                end
                ST_SRCH_CMP:
                begin
                    if (alu_flags.lt)
                    begin
                        pos_reg <= pos_reg + CNT_W'(1);
                    end
                    else if (!alu_flags.eq)
                    begin
                        dst_reg <= dst_init;
                    end
                end
                ST_SHF_WR:
                begin
                    dst_reg <= dst_reg - ADDR_W'(1);
                end
                ST_INS:
                begin
                    if (!count_full)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                end
                ST_EM_START:
                begin
                    k_reg <= '0;
                end
                ST_EM_OUT:
                begin
                    if (slot_free)
                    begin
                        if (emit_last)
                        begin
                            count_reg   <= '0;
                            lowest_reg  <= '1;
                            highest_reg <= '0;
                            any_reg     <= 1'b0;
                        end
                        else
                        begin
                            k_reg <= k_reg + ADDR_W'(1);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg     <= op;
            is_ask_reg <= is_ask;
            price_reg  <= price;
            size_reg   <= size;
        end
        if (state_reg == ST_EM_START)
        begin
            base_reg  <= any_reg ? lowest_reg : '0;
            range_reg <= any_reg ? alu_res : '0;
        end
        if (out_load)
        begin
            low_price_reg    <= base_reg;
            price_spread_reg <= range_reg;
            last_reg         <= emit_last;
            if (count_reg == '0)
            begin
                level_price_reg    <= '0;
                bid_total_reg      <= '0;
                ask_total_reg      <= '0;
                combined_count_reg <= '0;
                level_valid_reg    <= 1'b0;
            end
            else
            begin
                level_price_reg    <= ram_rd_data.price;
                bid_total_reg      <= ram_rd_data.bid;
                ask_total_reg      <= ram_rd_data.ask;
                combined_count_reg <= alu_res;
                level_valid_reg    <= op_reg;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign level_price    = level_price_reg;
    assign bid_total      = bid_total_reg;
    assign ask_total      = ask_total_reg;
    assign combined_count = combined_count_reg;
    assign low_price      = low_price_reg;
    assign price_spread   = price_spread_reg;
    assign level_valid    = level_valid_reg;
    assign last           = last_reg;

endmodule
